// ----- hdl/hxd_pkg.sv -----
// ----------------------------------------------------------------------------
// hxd_pkg: shared types and constants of the hextile stream decoder
// Field layouts of the input and result items, subencoding bits.
// ----------------------------------------------------------------------------
package hxd_pkg;
    localparam int TILE = 16;
    localparam int CW   = 16;

    localparam logic [4:0] SE_RAW = 5'd1;
    localparam logic [4:0] SE_BG  = 5'd2;
    localparam logic [4:0] SE_FG  = 5'd4;
    localparam logic [4:0] SE_ANY = 5'd8;
    localparam logic [4:0] SE_COL = 5'd16;

    typedef struct packed {
        logic        func;
        logic [15:0] rect_x;
        logic [15:0] rect_y;
        logic [15:0] rect_width;
        logic [15:0] rect_height;
        logic [7:0]  data_byte;
    } t_in;

    typedef struct packed {
        logic [15:0] fill_x;
        logic [15:0] fill_y;
        logic [4:0]  fill_width;
        logic [4:0]  fill_height;
        logic [23:0] fill_color;
        logic        rect_done;
    } t_out;
endpackage

// ----- hdl/hextile_stream_decoder.sv -----
// Pipeline: three register stages, the input register, the parser output register and the
//   result queue; a fill command passes through them in that order.
// Throughput: one input item per cycle while the output side keeps up.
// A four-entry result queue parts the sides; input stalls only when it has
//   two or more entries waiting.
// Reset: synchronous active low; parser idle, colors black/white, queue empty.
// ----------------------------------------------------------------------------
// hextile_stream_decoder: top level
// Input register, hextile parser and result queue.
// ----------------------------------------------------------------------------
module hextile_stream_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // rect_x, rect_y, rect_width, rect_height, data_byte
    input  logic        s_axis_tuser,  // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,  // fill_x, fill_y, fill_width, fill_height, fill_color, pad
    output logic        m_axis_tlast   // rect_done
);
    import hxd_pkg::*;

    t_in  r_item;
    logic r_v;
    logic p_v, room;
    t_out p_fill, q_fill;

    assign s_axis_tready = room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= 1'b0;
        else          r_v <= s_axis_tvalid && s_axis_tready;
    end

    always_ff @(posedge i_clk) begin
        r_item <= '{func: s_axis_tuser, rect_x: s_axis_tdata[15:0],
                    rect_y: s_axis_tdata[31:16], rect_width: s_axis_tdata[47:32],
                    rect_height: s_axis_tdata[63:48], data_byte: s_axis_tdata[71:64]};
    end

    hxd_parse u_parse (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_v), .i_item(r_item),
        .o_valid(p_v), .o_fill(p_fill)
    );

    hxd_outq u_outq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(p_v), .i_fill(p_fill),
        .o_room(room), .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_fill(q_fill)
    );

    assign m_axis_tdata = {6'd0, q_fill.fill_color, q_fill.fill_height,
                           q_fill.fill_width, q_fill.fill_y, q_fill.fill_x};
    assign m_axis_tlast = q_fill.rect_done;
endmodule

// ----- hdl/hxd_parse.sv -----
// ----------------------------------------------------------------------------
// hxd_parse: hextile parser
// Takes one registered item per cycle, updates parse state and gives at most
// one fill command.
// ----------------------------------------------------------------------------
module hxd_parse (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  hxd_pkg::t_in  i_item,
    output logic          o_valid,
    output hxd_pkg::t_out o_fill
);
    import hxd_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE, PH_SUBENC, PH_BG, PH_FG, PH_NSUB, PH_RAW, PH_SUBR
    } t_phase;

    t_phase      r_ph, n_ph;
    logic [15:0] r_bx, r_by, r_bw, r_bh, n_bx, n_by, n_bw, n_bh;
    logic [15:0] r_ox, r_oy, n_ox, n_oy;
    logic [4:0]  r_sw, r_sh, n_sw, n_sh;
    logic [23:0] r_bg, r_fg, n_bg, n_fg;
    logic [4:0]  r_se, n_se;
    logic [8:0]  r_left, n_left;
    logic [39:0] r_asm, n_asm;
    logic [2:0]  r_bi, n_bi;
    // raw pixel position inside the tile, replaces idx % / idx /
    logic [3:0]  r_px, r_py, n_px, n_py;

    logic [16:0] nx, ny, rw, rh;
    logic        lastt;
    logic [7:0]  b;
    logic [31:0] pix;
    logic        sub_col;
    logic [2:0]  need_m1;
    logic [7:0]  xy;
    logic [4:0]  sx, sy, sw, sh, lw, lh;
    logic        e_v;
    t_out        e;
    logic [23:0] col;

    always_comb begin
        b      = i_item.data_byte;
        // little-endian color word including the current byte
        pix    = r_asm[31:0] | ({24'd0, b} << {r_bi[1:0], 3'd0});
        n_ph = r_ph; n_bx = r_bx; n_by = r_by; n_bw = r_bw; n_bh = r_bh;
        n_ox = r_ox; n_oy = r_oy; n_sw = r_sw; n_sh = r_sh;
        n_bg = r_bg; n_fg = r_fg; n_se = r_se; n_left = r_left;
        n_asm = r_asm; n_bi = r_bi; n_px = r_px; n_py = r_py;
        e_v = 1'b0;
        e   = '0;
        lastt = ({1'b0, r_ox} + {12'd0, r_sw} >= {1'b0, r_bw})
             && ({1'b0, r_oy} + {12'd0, r_sh} >= {1'b0, r_bh});
        sub_col = (r_se & SE_COL) != 5'd0;
        need_m1 = sub_col ? 3'd5 : 3'd1;
        xy  = sub_col ? r_asm[39:32] : r_asm[7:0];
        col = 24'd0;
        sx = {1'b0, xy[7:4]};
        sy = {1'b0, xy[3:0]};
        sw = {1'b0, b[7:4]} + 5'd1;
        sh = {1'b0, b[3:0]} + 5'd1;
        lw = r_sw - sx;
        lh = r_sh - sy;
        nx = {1'b0, r_ox} + 17'd16;
        ny = {1'b0, r_oy};
        rw = 17'd0; rh = 17'd0;
        if (!i_item.func) begin
            n_bx = i_item.rect_x; n_by = i_item.rect_y;
            n_bw = i_item.rect_width; n_bh = i_item.rect_height;
            n_ox = '0; n_oy = '0;
            if (n_bw == 0 || n_bh == 0) begin
                n_ph = PH_IDLE;
            end else begin
                n_sw = (n_bw < 16'd16) ? n_bw[4:0] : 5'd16;
                n_sh = (n_bh < 16'd16) ? n_bh[4:0] : 5'd16;
                n_ph = PH_SUBENC; n_bi = '0; n_asm = '0; n_left = '0;
            end
        end else begin
            case (r_ph)
                PH_SUBENC: begin
                    n_se = b[4:0];
                    n_bi = '0; n_asm = '0;
                    n_px = '0; n_py = '0;
                    if ((b[4:0] & SE_RAW) != 5'd0) begin
                        n_left = 9'({4'd0, r_sw} * {4'd0, r_sh});
                        n_ph = PH_RAW;
                    end else if ((b[4:0] & SE_BG) != 5'd0) n_ph = PH_BG;
                    else if ((b[4:0] & SE_FG) != 5'd0) n_ph = PH_FG;
                    else if ((b[4:0] & SE_ANY) != 5'd0) n_ph = PH_NSUB;
                    else begin
                        e_v = 1'b1; e.fill_color = r_bg; e.rect_done = lastt;
                    end
                end
                PH_BG, PH_FG: begin
                    n_asm[31:0] = pix;
                    n_bi = r_bi + 3'd1;
                    if (r_bi == 3'd3) begin
                        n_bi = '0; n_asm = '0;
                        if (r_ph == PH_BG) begin
                            n_bg = pix[23:0];
                            if ((r_se & SE_FG) != 5'd0) n_ph = PH_FG;
                            else if ((r_se & SE_ANY) != 5'd0) n_ph = PH_NSUB;
                            else begin
                                e_v = 1'b1; e.fill_color = pix[23:0];
                                e.rect_done = lastt;
                            end
                        end else begin
                            n_fg = pix[23:0];
                            if ((r_se & SE_ANY) != 5'd0) n_ph = PH_NSUB;
                            else begin
                                e_v = 1'b1; e.fill_color = r_bg; e.rect_done = lastt;
                            end
                        end
                    end
                end
                PH_NSUB: begin
                    e_v = 1'b1; e.fill_color = r_bg;
                    e.rect_done = lastt && b == 8'd0;
                    if (b != 8'd0) begin
                        n_left = {1'b0, b}; n_bi = '0; n_asm = '0; n_ph = PH_SUBR;
                    end
                end
                PH_RAW: begin
                    n_asm[31:0] = pix;
                    n_bi = r_bi + 3'd1;
                    if (r_bi == 3'd3) begin
                        n_bi = '0; n_asm = '0;
                        n_left = r_left - 9'd1;
                        e_v = 1'b1;
                        e.fill_color = pix[23:0];
                        e.fill_x = r_bx + r_ox + {12'd0, r_px};
                        e.fill_y = r_by + r_oy + {12'd0, r_py};
                        e.fill_width = 5'd1; e.fill_height = 5'd1;
                        e.rect_done = n_left == 0 && lastt;
                        if ({1'b0, r_px} + 5'd1 >= r_sw) begin
                            n_px = '0; n_py = r_py + 4'd1;
                        end else n_px = r_px + 4'd1;
                    end
                end
                PH_SUBR: begin
                    if (r_bi < need_m1) begin
                        n_asm = r_asm | ({32'd0, b} << {r_bi, 3'd0});
                        n_bi = r_bi + 3'd1;
                    end else begin
                        col = sub_col ? r_asm[23:0] : r_fg;
                        n_left = r_left - 9'd1;
                        n_bi = '0; n_asm = '0;
                        if (sx < r_sw && sy < r_sh) begin
                            e_v = 1'b1; e.fill_color = col;
                            e.fill_x = r_bx + r_ox + {11'd0, sx};
                            e.fill_y = r_by + r_oy + {11'd0, sy};
                            e.fill_width = (sw > lw) ? lw : sw;
                            e.fill_height = (sh > lh) ? lh : sh;
                            e.rect_done = n_left == 0 && lastt;
                        end
                    end
                end
                default: ;
            endcase
            // background fill carries the tile box
            if (e_v && r_ph != PH_RAW && r_ph != PH_SUBR) begin
                e.fill_x = r_bx + r_ox; e.fill_y = r_by + r_oy;
                e.fill_width = r_sw; e.fill_height = r_sh;
            end
            // tile end
            if ((e_v && r_ph != PH_RAW && r_ph != PH_SUBR && n_ph == r_ph
                 && r_ph != PH_BG && r_ph != PH_FG)
                || (e_v && (r_ph == PH_BG || r_ph == PH_FG) && n_ph == r_ph)
                || (r_ph == PH_RAW && r_bi == 3'd3 && n_left == 0)
                || (r_ph == PH_SUBR && r_bi >= need_m1 && n_left == 0)) begin
                if (nx >= {1'b0, r_bw}) begin
                    nx = '0; ny = {1'b0, r_oy} + 17'd16;
                end
                n_ox = nx[15:0]; n_oy = ny[15:0];
                if (ny >= {1'b0, r_bh}) n_ph = PH_IDLE;
                else begin
                    rw = {1'b0, r_bw} - nx; rh = {1'b0, r_bh} - ny;
                    n_sw = (rw < 17'd16) ? rw[4:0] : 5'd16;
                    n_sh = (rh < 17'd16) ? rh[4:0] : 5'd16;
                    n_ph = PH_SUBENC; n_bi = '0; n_asm = '0; n_left = '0;
                end
            end
        end
        if (!i_valid) e_v = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= PH_IDLE; r_bx <= '0; r_by <= '0; r_bw <= '0; r_bh <= '0;
            r_ox <= '0; r_oy <= '0; r_sw <= '0; r_sh <= '0;
            r_bg <= '0; r_fg <= 24'hffffff; r_se <= '0; r_left <= '0;
            r_asm <= '0; r_bi <= '0; r_px <= '0; r_py <= '0;
            o_valid <= 1'b0;
        end else begin
            if (i_valid) begin
                r_ph <= n_ph; r_bx <= n_bx; r_by <= n_by; r_bw <= n_bw; r_bh <= n_bh;
                r_ox <= n_ox; r_oy <= n_oy; r_sw <= n_sw; r_sh <= n_sh;
                r_bg <= n_bg; r_fg <= n_fg; r_se <= n_se; r_left <= n_left;
                r_asm <= n_asm; r_bi <= n_bi; r_px <= n_px; r_py <= n_py;
            end
            o_valid <= e_v;
        end
    end

    always_ff @(posedge i_clk) begin
        o_fill <= e;
    end
endmodule

// ----- hdl/hxd_outq.sv -----
// ----------------------------------------------------------------------------
// hxd_outq: four-entry result queue
// Holds fill commands while the sink waits; input stalls once two are held.
// ----------------------------------------------------------------------------
module hxd_outq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  hxd_pkg::t_out i_fill,
    output logic          o_room,
    output logic          o_valid,
    input  logic          i_ready,
    output hxd_pkg::t_out o_fill
);
    import hxd_pkg::*;

    t_out       r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       pop;

    assign pop     = o_valid && i_ready;
    assign o_valid = r_cnt != 3'd0;
    assign o_fill  = r_mem[r_rp];
    // parser + input register hold up to two in flight
    assign o_room  = r_cnt < 3'd2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_valid) r_wp <= r_wp + 2'd1;
            if (pop) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'd0, i_valid} - {2'd0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) r_mem[r_wp] <= i_fill;
    end
endmodule

// ----- hdl/hxd_check.sv -----
// ----------------------------------------------------------------------------
// hxd_check: port checker for the hextile stream decoder
// Watches handshakes and result ranges on the top-level ports.
// ----------------------------------------------------------------------------
module hxd_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
        else $error("result changed while stalled");
    a_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[36:32] != 5'd0 && m_axis_tdata[36:32] <= 5'd16)
        else $error("fill width out of range");
    a_height: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[41:37] != 5'd0 && m_axis_tdata[41:37] <= 5'd16)
        else $error("fill height out of range");
    a_idle_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("result right after reset");
    // input backpressure only comes from waiting results
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result waiting");
endmodule

bind hextile_stream_decoder hxd_check u_hxd_check (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
);

// ----- dv/hextile_stream_decoder_test.sv -----
// ----------------------------------------------------------------------------
// hextile_stream_decoder_test: self-checking bench for the hextile decoder
// Feeds rectangle headers and hextile byte streams, predicts each fill
// command and compares it with the output stream under random stalls.
// ----------------------------------------------------------------------------
module hextile_stream_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;
    import hxd_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE, PH_SUBENC, PH_BG, PH_FG, PH_NSUB, PH_RAW, PH_SUBR
    } t_phase;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;  // rect_x, rect_y, rect_width, rect_height, data_byte
    logic        s_axis_tuser;  // func
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;  // fill_x, fill_y, fill_width, fill_height, fill_color, pad
    logic        m_axis_tlast;  // rect_done

    hextile_stream_decoder u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    t_in    pending_items[$];
    t_out   expected_fills[$];
    int     send_idle_pct;
    int     recv_stall_pct;
    int     error_count;
    int     fill_count;
    int     done_count;
    int     items_sent;

    // acceptance flag, set on the rising edge of a transaction
    logic s_axis_tready_seen;

    // predictor state
    t_phase      phase;
    logic [15:0] box_x, box_y;
    logic [31:0] box_w, box_h, org_x, org_y, tile_w, tile_h;
    logic [23:0] bg_color, fg_color;
    logic [4:0]  subenc;
    logic [31:0] items_left;
    logic [63:0] assembly;
    logic [31:0] byte_idx;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic bit is_last_tile();
        return (org_x + tile_w >= box_w) && (org_y + tile_h >= box_h);
    endfunction

    task automatic start_tile();
        logic [31:0] rw, rh;
        rw = box_w - org_x;
        rh = box_h - org_y;
        tile_w = (rw < TILE) ? rw : TILE;
        tile_h = (rh < TILE) ? rh : TILE;
        phase = PH_SUBENC;
        byte_idx = 0;
        assembly = 0;
        items_left = 0;
    endtask

    task automatic next_tile();
        org_x += TILE;
        if (org_x >= box_w) begin
            org_x = 0;
            org_y += TILE;
            if (org_y >= box_h) begin
                phase = PH_IDLE;
                return;
            end
        end
        start_tile();
    endtask

    task automatic push_fill(logic [31:0] dx, logic [31:0] dy, logic [31:0] w,
                             logic [31:0] h, logic [23:0] color, bit done);
        t_out f;
        logic [31:0] ax, ay;
        ax = {16'd0, box_x} + org_x + dx;
        ay = {16'd0, box_y} + org_y + dy;
        f.fill_x = ax[15:0];
        f.fill_y = ay[15:0];
        f.fill_width = w[4:0];
        f.fill_height = h[4:0];
        f.fill_color = color;
        f.rect_done = done;
        expected_fills.push_back(f);
    endtask

    task automatic advance_header(t_phase after);
        byte_idx = 0;
        assembly = 0;
        if (after < PH_BG && (subenc & SE_BG) != 5'd0) begin
            phase = PH_BG;
            return;
        end
        if (after < PH_FG && (subenc & SE_FG) != 5'd0) begin
            phase = PH_FG;
            return;
        end
        if (after < PH_NSUB && (subenc & SE_ANY) != 5'd0) begin
            phase = PH_NSUB;
            return;
        end
        push_fill(0, 0, tile_w, tile_h, bg_color, is_last_tile());
        next_tile();
    endtask

    task automatic predict_fill(t_in it);
        logic [7:0]  b;
        logic [31:0] need, xy, sx, sy, sw, sh, idx;
        logic [23:0] color;
        bit          last;
        b = it.data_byte;
        if (!it.func) begin
            box_x = it.rect_x;
            box_y = it.rect_y;
            box_w = {16'd0, it.rect_width};
            box_h = {16'd0, it.rect_height};
            org_x = 0;
            org_y = 0;
            if (box_w == 0 || box_h == 0) phase = PH_IDLE;
            else start_tile();
            return;
        end
        case (phase)
            PH_SUBENC: begin
                subenc = b[4:0];
                if ((subenc & SE_RAW) != 5'd0) begin
                    items_left = tile_w * tile_h;
                    byte_idx = 0;
                    assembly = 0;
                    phase = PH_RAW;
                end else begin
                    advance_header(PH_SUBENC);
                end
            end
            PH_BG, PH_FG: begin
                assembly |= 64'(b) << (8 * byte_idx[1:0]);
                byte_idx++;
                if (byte_idx >= 4) begin
                    if (phase == PH_BG) begin
                        bg_color = assembly[23:0];
                        advance_header(PH_BG);
                    end else begin
                        fg_color = assembly[23:0];
                        advance_header(PH_FG);
                    end
                end
            end
            PH_NSUB: begin
                push_fill(0, 0, tile_w, tile_h, bg_color, is_last_tile() && b == 0);
                if (b == 0) begin
                    next_tile();
                end else begin
                    items_left = {24'd0, b};
                    byte_idx = 0;
                    assembly = 0;
                    phase = PH_SUBR;
                end
            end
            PH_RAW: begin
                assembly |= 64'(b) << (8 * byte_idx[1:0]);
                byte_idx++;
                if (byte_idx >= 4) begin
                    color = assembly[23:0];
                    byte_idx = 0;
                    assembly = 0;
                    idx = tile_w * tile_h - items_left;
                    items_left--;
                    push_fill(idx % tile_w, idx / tile_w, 1, 1, color,
                              items_left == 0 && is_last_tile());
                    if (items_left == 0) next_tile();
                end
            end
            PH_SUBR: begin
                need = ((subenc & SE_COL) != 5'd0) ? 6 : 2;
                if (byte_idx + 1 < need) begin
                    assembly |= 64'(b) << (8 * byte_idx[2:0]);
                    byte_idx++;
                end else begin
                    xy = 32'((assembly >> (8 * (need - 2))) & 64'hff);
                    color = (need == 6) ? assembly[23:0] : fg_color;
                    sx = xy >> 4;
                    sy = xy & 15;
                    sw = (b >> 4) + 1;
                    sh = (b & 15) + 1;
                    items_left--;
                    last = (items_left == 0);
                    if (sx < tile_w && sy < tile_h) begin
                        // clip to the tile edge
                        if (sw > tile_w - sx) sw = tile_w - sx;
                        if (sh > tile_h - sy) sh = tile_h - sy;
                        push_fill(sx, sy, sw, sh, color, last && is_last_tile());
                    end
                    byte_idx = 0;
                    assembly = 0;
                    if (last) next_tile();
                end
            end
            default: ;
        endcase
    endtask

    // driver
    always @(negedge i_clk) begin
        t_in it;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready_seen) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                it = pending_items.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= it.func;
                s_axis_tdata  <= {it.data_byte, it.rect_height, it.rect_width,
                                  it.rect_y, it.rect_x};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // input and output monitor
    always @(posedge i_clk) begin
        t_in  acc;
        t_out got, want;
        s_axis_tready_seen <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            acc.func        = s_axis_tuser;
            acc.rect_x      = s_axis_tdata[15:0];
            acc.rect_y      = s_axis_tdata[31:16];
            acc.rect_width  = s_axis_tdata[47:32];
            acc.rect_height = s_axis_tdata[63:48];
            acc.data_byte   = s_axis_tdata[71:64];
            predict_fill(acc);
            items_sent++;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.fill_x      = m_axis_tdata[15:0];
            got.fill_y      = m_axis_tdata[31:16];
            got.fill_width  = m_axis_tdata[36:32];
            got.fill_height = m_axis_tdata[41:37];
            got.fill_color  = m_axis_tdata[65:42];
            got.rect_done   = m_axis_tlast;
            fill_count++;
            if (got.rect_done) done_count++;
            if (expected_fills.size() == 0) begin
                $display("%0t: unexpected fill x=%0d y=%0d w=%0d h=%0d c=%06h done=%0b",
                         $time, got.fill_x, got.fill_y, got.fill_width,
                         got.fill_height, got.fill_color, got.rect_done);
                error_count++;
            end else begin
                want = expected_fills.pop_front();
                if (got !== want) begin
                    $display("%0t: fill mismatch expected x=%0d y=%0d w=%0d h=%0d c=%06h d=%0b",
                             $time, want.fill_x, want.fill_y, want.fill_width,
                             want.fill_height, want.fill_color, want.rect_done);
                    $display("%0t:                 actual x=%0d y=%0d w=%0d h=%0d c=%06h d=%0b",
                             $time, got.fill_x, got.fill_y, got.fill_width,
                             got.fill_height, got.fill_color, got.rect_done);
                    error_count++;
                end
            end
        end
    end

    function automatic t_in header_item(int x, int y, int w, int h);
        t_in it;
        it = '0;
        it.rect_x = 16'(x);
        it.rect_y = 16'(y);
        it.rect_width = 16'(w);
        it.rect_height = 16'(h);
        return it;
    endfunction

    function automatic t_in data_item(int b);
        t_in it;
        it = '0;
        it.func = 1'b1;
        it.data_byte = 8'(b);
        // junk in the header fields, ignored on data bytes
        it.rect_x = 16'($urandom);
        it.rect_y = 16'($urandom);
        it.rect_width = 16'($urandom);
        it.rect_height = 16'($urandom);
        return it;
    endfunction

    task automatic add_color();
        repeat (4) pending_items.push_back(data_item($urandom_range(255)));
    endtask

    // one well-formed tile with random content; raw only on small tiles
    task automatic add_tile(int w, int h);
        int se, n;
        se = $urandom_range(31);
        if ($urandom_range(3) != 0 || w * h > 8) se &= ~SE_RAW;
        pending_items.push_back(data_item(se | ($urandom_range(7) << 5)));
        if (se & SE_RAW) begin
            repeat (w * h) add_color();
            return;
        end
        if (se & SE_BG) add_color();
        if (se & SE_FG) add_color();
        if (se & SE_ANY) begin
            n = ($urandom_range(4) == 0) ? 0 : $urandom_range(1, 4);
            pending_items.push_back(data_item(n));
            repeat (n) begin
                if (se & SE_COL) add_color();
                pending_items.push_back(data_item($urandom_range(255)));
                pending_items.push_back(data_item($urandom_range(255)));
            end
        end
    endtask

    task automatic add_rect(int x, int y, int w, int h);
        pending_items.push_back(header_item(x, y, w, h));
        for (int ty = 0; ty < h; ty += TILE)
            for (int tx = 0; tx < w; tx += TILE)
                add_tile((w - tx < TILE) ? w - tx : TILE, (h - ty < TILE) ? h - ty : TILE);
    endtask

    task automatic run_phase(int idle, int stall, int n_items);
        int target, w, h;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        target = pending_items.size() + n_items;
        while (pending_items.size() < target) begin
            case ($urandom_range(9))
                0: pending_items.push_back(header_item($urandom, $urandom, 0, $urandom));
                1: pending_items.push_back(data_item($urandom_range(255)));
                2: begin
                    // broken rectangle: abandoned by the next header
                    pending_items.push_back(header_item($urandom, $urandom, 20, 20));
                    repeat ($urandom_range(1, 6))
                        pending_items.push_back(data_item($urandom_range(255)));
                end
                default: begin
                    w = ($urandom_range(7) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
                    h = ($urandom_range(7) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
                    if ($urandom_range(3) == 0) w = $urandom_range(1, 3);
                    add_rect($urandom, $urandom, w, h);
                end
            endcase
        end
        wait (pending_items.size() == 0 && !s_axis_tvalid);
        wait (expected_fills.size() == 0);
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        error_count = 0;
        fill_count = 0;
        done_count = 0;
        items_sent = 0;
        phase = PH_IDLE;
        box_x = 0; box_y = 0; box_w = 0; box_h = 0;
        org_x = 0; org_y = 0; tile_w = 0; tile_h = 0;
        bg_color = '0;
        fg_color = 24'hffffff;
        subenc = '0;
        items_left = 0;
        assembly = 0;
        byte_idx = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: idle byte, empty rectangles, corner coordinates, every subencoding bit
        pending_items.push_back(data_item(8'hff));
        pending_items.push_back(header_item(16'hffff, 16'hffff, 0, 5));
        pending_items.push_back(header_item(0, 0, 5, 0));
        pending_items.push_back(header_item(16'hfff8, 16'hfffc, 1, 1));
        pending_items.push_back(data_item(0));          // background fill only
        pending_items.push_back(header_item(0, 0, 2, 1));
        pending_items.push_back(data_item(SE_RAW | SE_BG));
        repeat (2) begin
            pending_items.push_back(data_item(8'hff));
            pending_items.push_back(data_item(8'h00));
            pending_items.push_back(data_item(8'hff));
            pending_items.push_back(data_item(8'h80));
        end
        pending_items.push_back(header_item(100, 200, 4, 4));
        pending_items.push_back(data_item(SE_BG | SE_FG | SE_ANY));
        add_color();
        add_color();
        pending_items.push_back(data_item(2));
        pending_items.push_back(data_item(8'h33));      // overhanging, clipped
        pending_items.push_back(data_item(8'hff));
        pending_items.push_back(data_item(8'h50));      // origin outside, dropped
        pending_items.push_back(data_item(8'h00));
        pending_items.push_back(header_item(16'hffff, 0, 16'hffff, 16'hffff));
        pending_items.push_back(data_item(SE_ANY | SE_COL));
        pending_items.push_back(data_item(1));
        add_color();
        pending_items.push_back(data_item(8'hf0));
        pending_items.push_back(data_item(8'h0f));

        run_phase(0, 0, 230);
        run_phase(59, 0, 200);
        run_phase(0, 59, 200);
        run_phase(37, 37, 200);
        repeat (20) @(posedge i_clk);

        $display("Sent %0d items, checked %0d fills (%0d rectangle ends).",
                 items_sent, fill_count, done_count);
        if (error_count == 0 && expected_fills.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

// ----- filelist.f -----
hdl/hxd_pkg.sv
hdl/hxd_parse.sv
hdl/hxd_outq.sv
hdl/hextile_stream_decoder.sv
hdl/hxd_check.sv
dv/hextile_stream_decoder_test.sv
